// ===== design/maf_pkg.sv =====
// Shared types and constants of the moving average filter.
package maf_pkg;

   localparam int SAMPLE_W = 32;
   localparam int SUM_W    = 38;
   localparam int AVG_W    = 16;
   localparam int TAPS_W   = 7;

   localparam logic [TAPS_W-1:0] TAPS_RESET = TAPS_W'(8);

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [SUM_W-1:0]    sum_type;
   typedef logic signed [AVG_W-1:0]    avg_type;
   typedef logic [TAPS_W-1:0]          taps_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_START,
      ST_DIVIDE,
      ST_OUTPUT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic update;
      logic div_start;
      logic load_out;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_busy;
      logic div_done;
   } status_type;

endpackage

// ===== design/maf_req_if.sv =====
// Input channel carrying one sample per item.
interface maf_req_if import maf_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

// ===== design/maf_rsp_if.sv =====
// Result channel carrying the window sum and the average per item.
interface maf_rsp_if import maf_pkg::*; ();
   logic    valid;
   logic    ready;
   sum_type window_sum;
   avg_type average;

   modport source (output valid, output window_sum, output average, input ready);
   modport sink   (input valid, input window_sum, input average, output ready);
endinterface

// ===== design/maf_divider.sv =====
// Restoring divider: signed sum over unsigned window length, one quotient bit per cycle.
module maf_divider import maf_pkg::*; #(
   parameter int NW = 7
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  sum_type       dividend,
   input  logic [NW-1:0] divisor,
   output logic          busy,
   output logic          done,
   output sum_type       quotient
);

   localparam int CNT_W = $clog2(SUM_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(SUM_W - 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0] quo_ff, quo_in;
   logic [NW:0]      rem_ff, rem_in;
   logic [NW-1:0]    divisor_ff, divisor_in;
   logic             neg_ff, neg_in;

   logic [NW:0]      rem_shift;
   logic [NW:0]      rem_diff;
   logic             fits;

   always_comb begin
      rem_shift = {rem_ff[NW-1:0], quo_ff[SUM_W-1]};
      rem_diff  = rem_shift - {1'b0, divisor_ff};
      fits      = rem_shift >= {1'b0, divisor_ff};

      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      neg_in     = neg_ff;

      if (start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         rem_in     = '0;
         divisor_in = divisor;
         neg_in     = dividend[SUM_W-1];
         // The magnitude of the most negative sum still fits as unsigned.
         quo_in     = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
      end else if (busy_ff) begin
         rem_in   = fits ? rem_diff : rem_shift;
         quo_in   = {quo_ff[SUM_W-2:0], fits};
         count_in = count_ff + 1'b1;
         if (count_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff   <= count_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      neg_ff     <= neg_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = neg_ff ? sum_type'(-quo_ff) : sum_type'(quo_ff);

endmodule

// ===== design/maf_datapath.sv =====
// Sample store, running sum, write index, window length and result registers.
module maf_datapath import maf_pkg::*; #(
   parameter int MAX_TAPS  = 64,
   parameter int FRAC_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  taps_type   csr_wdata,
   input  cmd_type    cmd,
   output status_type status,
   input  sample_type req_sample,
   output sum_type    rsp_window_sum,
   output avg_type    rsp_average
);

   localparam int IW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int NW = $clog2(MAX_TAPS + 1);

   sample_type          mem [MAX_TAPS];
   logic [MAX_TAPS-1:0] valid_ff, valid_in;
   taps_type            taps_ff;
   logic [IW-1:0]       windex_ff, windex_in;
   logic [IW-1:0]       slot_ff;
   sum_type             sum_ff, sum_in;
   sample_type          sample_ff;
   sample_type          rd_data_ff;
   logic                rd_valid_ff;
   sum_type             out_sum_ff;
   avg_type             out_avg_ff, out_avg_in;

   logic [7:0]          taps_ext;
   logic [7:0]          n_ext;
   logic [NW-1:0]       n_eff;
   logic [IW-1:0]       rd_index;
   logic [8:0]          next_index;
   sample_type          old_sample;
   logic                div_busy, div_done;
   sum_type             quotient;
   sum_type             avg_full;
   logic [SUM_W-AVG_W:0] avg_high;

   // A written zero acts as one; anything above the store depth acts as the depth.
   always_comb begin
      taps_ext = 8'(taps_ff);
      if (taps_ext == '0) begin
         n_ext = 8'd1;
      end else if (taps_ext > 8'(MAX_TAPS)) begin
         n_ext = 8'(MAX_TAPS);
      end else begin
         n_ext = taps_ext;
      end
      n_eff = n_ext[NW-1:0];
   end

   always_comb begin
      rd_index   = (9'(windex_ff) >= 9'(n_eff)) ? '0 : windex_ff;
      old_sample = rd_valid_ff ? rd_data_ff : '0;
      next_index = 9'(slot_ff) + 9'd1;
      sum_in     = sum_ff;
      windex_in  = windex_ff;
      valid_in   = valid_ff;
      if (csr_we) begin
         sum_in    = '0;
         windex_in = '0;
         valid_in  = '0;
      end else if (cmd.update) begin
         sum_in    = sum_ff + SUM_W'(sample_ff) - SUM_W'(old_sample);
         windex_in = (next_index >= 9'(n_eff)) ? '0 : next_index[IW-1:0];
         valid_in[slot_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         taps_ff   <= TAPS_RESET;
         sum_ff    <= '0;
         windex_ff <= '0;
         valid_ff  <= '0;
      end else begin
         if (csr_we) begin
            taps_ff <= csr_wdata;
         end
         sum_ff    <= sum_in;
         windex_ff <= windex_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sample_ff   <= req_sample;
         slot_ff     <= rd_index;
         rd_data_ff  <= mem[rd_index];
         rd_valid_ff <= valid_ff[rd_index];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         mem[slot_ff] <= sample_ff;
      end
   end

   maf_divider #(
      .NW (NW)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (sum_ff),
      .divisor  (n_eff),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (quotient)
   );

   // Floor shift of the truncated quotient, then saturation to the output width.
   always_comb begin
      avg_full = quotient >>> FRAC_BITS;
      avg_high = avg_full[SUM_W-1:AVG_W-1];
      if (avg_high != '0 && avg_high != '1) begin
         out_avg_in = avg_full[SUM_W-1] ? {1'b1, {(AVG_W-1){1'b0}}}
                                        : {1'b0, {(AVG_W-1){1'b1}}};
      end else begin
         out_avg_in = avg_full[AVG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_sum_ff <= sum_ff;
         out_avg_ff <= out_avg_in;
      end
   end

   assign status.div_busy = div_busy;
   assign status.div_done = div_done;
   assign rsp_window_sum  = out_sum_ff;
   assign rsp_average     = out_avg_ff;

endmodule

// ===== design/maf_ctrl.sv =====
// Controller that sequences one item through store read, sum update, divide and output.
module maf_ctrl import maf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      out_free     = !rsp_valid_ff || rsp_ready;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_START;
         end
         ST_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            // The previous result must be taken before this one replaces it.
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== design/moving_average_filter.sv =====
// Moving average filter over the last taps samples, kept as a running sum in a
// sample store of MAX_TAPS entries. One item is in work at a time. The store is
// read at the edge that accepts the item; then follow the sum update, a divider
// load, the bit-serial divider that divides the 38-bit sum by the window length,
// a state in which the controller sees the divider finish, and the result load,
// which waits until the previous result has been taken. The controller then
// returns to idle, so a new item is taken only once the last one is loaded.
// A finished result waits in its output register while the next item is taken.
// Writing csr_wdata with csr_we empties the store, the write index and the sum;
// it must only be done while no item is in work. A window length of zero acts as
// one, and one above MAX_TAPS acts as MAX_TAPS.
module moving_average_filter import maf_pkg::*; #(
   parameter int MAX_TAPS  = 64,
   parameter int FRAC_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   maf_req_if.sink          req_ch,
   maf_rsp_if.source        rsp_ch,
   input  logic             csr_we,
   input  logic [TAPS_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   maf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   maf_datapath #(
      .MAX_TAPS  (MAX_TAPS),
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .cmd            (cmd),
      .status         (status),
      .req_sample     (req_ch.sample),
      .rsp_window_sum (rsp_ch.window_sum),
      .rsp_average    (rsp_ch.average)
   );

   // Only one item is in work: after an acceptance the input side closes.
   assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("input accepted while an item is in work");

   // A new result never replaces one that has not been taken.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_ch.valid || rsp_ch.ready))
      else $error("pending result overwritten");

   // A divider start is followed by a running divide.
   assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> status.div_busy)
      else $error("divider did not start");

   // The divider reports completion only after it stops running.
   assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> !status.div_busy && $past(status.div_busy))
      else $error("divider done without a preceding divide");

endmodule
